/* design/ncas_pkg.sv */
package ncas_pkg;

   localparam int unsigned NUM_CENTERS_DEF = 3;
   localparam int unsigned COORD_W         = 16;
   localparam int unsigned SQ_W            = 2 * COORD_W;
   localparam int unsigned DIST_W          = 34;
   localparam int unsigned SSE_W           = 42;
   localparam int unsigned IDX_W           = 4;

   localparam logic [SSE_W-1:0]  SSE_MAX  = {SSE_W{1'b1}};
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_POINT = 1'b1;

   typedef struct packed {
      logic               op;
      logic [IDX_W-1:0]   center_slot;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
      logic [COORD_W-1:0] coord_w;
      logic               set_end;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  cluster;
      logic [DIST_W-1:0] distance_sq;
      logic [SSE_W-1:0]  sse_total;
      logic              is_last;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] w;
   } point_type;

   typedef struct packed {
      logic              valid;
      logic              set_end;
      point_type         point;
      logic [DIST_W-1:0] best_d;
      logic [IDX_W-1:0]  best_idx;
   } token_type;

endpackage

/* design/ncas_cell.sv */
module ncas_cell #(
   parameter logic [ncas_pkg::IDX_W-1:0] CELL_IDX = '0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_en,
   input  ncas_pkg::point_type load_data,
   input  ncas_pkg::token_type tok_in,
   output ncas_pkg::token_type tok_out,
   output logic                active
);

   function automatic logic [ncas_pkg::SQ_W-1:0] sq_diff(
      input logic [ncas_pkg::COORD_W-1:0] a,
      input logic [ncas_pkg::COORD_W-1:0] b
   );
      logic [ncas_pkg::COORD_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return ncas_pkg::SQ_W'(d) * ncas_pkg::SQ_W'(d);
   endfunction

   ncas_pkg::point_type center_ff;

   logic                         valid_s1_ff, valid_s1_in;
   logic                         set_end_s1_ff;
   ncas_pkg::point_type          point_s1_ff;
   logic [ncas_pkg::DIST_W-1:0]  best_d_s1_ff;
   logic [ncas_pkg::IDX_W-1:0]   best_idx_s1_ff;
   logic [ncas_pkg::SQ_W-1:0]    sq_x_ff, sq_y_ff, sq_z_ff, sq_w_ff;

   ncas_pkg::token_type          tok_ff, tok_in_s2;
   logic [ncas_pkg::DIST_W-1:0]  dist_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
      end else if (load_en) begin
         center_ff <= load_data;
      end
   end

   assign valid_s1_in = tok_in.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
      end else begin
         valid_s1_ff <= valid_s1_in;
      end
   end

   always_ff @(posedge clock) begin
      set_end_s1_ff  <= tok_in.set_end;
      point_s1_ff    <= tok_in.point;
      best_d_s1_ff   <= tok_in.best_d;
      best_idx_s1_ff <= tok_in.best_idx;
      sq_x_ff        <= sq_diff(tok_in.point.x, center_ff.x);
      sq_y_ff        <= sq_diff(tok_in.point.y, center_ff.y);
      sq_z_ff        <= sq_diff(tok_in.point.z, center_ff.z);
      sq_w_ff        <= sq_diff(tok_in.point.w, center_ff.w);
   end

   assign dist_sum = ncas_pkg::DIST_W'(sq_x_ff) + ncas_pkg::DIST_W'(sq_y_ff)
                   + ncas_pkg::DIST_W'(sq_z_ff) + ncas_pkg::DIST_W'(sq_w_ff);

   always_comb begin
      tok_in_s2.valid   = valid_s1_ff;
      tok_in_s2.set_end = set_end_s1_ff;
      tok_in_s2.point   = point_s1_ff;
      if (dist_sum < best_d_s1_ff) begin
         tok_in_s2.best_d   = dist_sum;
         tok_in_s2.best_idx = CELL_IDX;
      end else begin
         tok_in_s2.best_d   = best_d_s1_ff;
         tok_in_s2.best_idx = best_idx_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_s2.valid;
      end
      tok_ff.set_end  <= tok_in_s2.set_end;
      tok_ff.point    <= tok_in_s2.point;
      tok_ff.best_d   <= tok_in_s2.best_d;
      tok_ff.best_idx <= tok_in_s2.best_idx;
   end

   assign tok_out = tok_ff;
   assign active  = valid_s1_ff | tok_ff.valid;

endmodule

/* design/ncas_accum.sv */
module ncas_accum (
   input  logic                clock,
   input  logic                reset,
   input  ncas_pkg::token_type tok_in,
   output logic                rsp_valid,
   output ncas_pkg::rsp_type   rsp_data
);

   logic [ncas_pkg::SSE_W-1:0] sse_ff, sse_in;
   logic [ncas_pkg::SSE_W:0]   sum_wide;
   logic [ncas_pkg::SSE_W-1:0] sum_sat;
   logic                       rsp_valid_ff;
   ncas_pkg::rsp_type          rsp_ff, rsp_in;

   assign sum_wide = {1'b0, sse_ff} + (ncas_pkg::SSE_W + 1)'(tok_in.best_d);
   assign sum_sat  = sum_wide[ncas_pkg::SSE_W] ? ncas_pkg::SSE_MAX
                                               : sum_wide[ncas_pkg::SSE_W-1:0];

   always_comb begin
      sse_in = sse_ff;
      if (tok_in.valid) begin
         sse_in = tok_in.set_end ? '0 : sum_sat;
      end
      rsp_in.cluster     = tok_in.best_idx;
      rsp_in.distance_sq = tok_in.best_d;
      rsp_in.sse_total   = sum_sat;
      rsp_in.is_last     = tok_in.set_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sse_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sse_ff       <= sse_in;
         rsp_valid_ff <= tok_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_in.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* design/nearest_center_assign_sse.sv */
// Load beat: applied at the accepting edge, no result, busy stays low.
// Point beat: result strobed after the last cell and the SSE stage; each center cell
// takes two register stages (square, then sum and compare), the first loading at the
// accepting edge, and the SSE stage one more.
// No new point until the last leaves the chain; one load every cycle while not busy.
// Reset: centers and SSE clear to zero, chain empties; the receiver cannot stall.
module nearest_center_assign_sse #(
   parameter int unsigned NUM_CENTERS = ncas_pkg::NUM_CENTERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ncas_pkg::req_type req_data,
   output logic              rsp_valid,
   output ncas_pkg::rsp_type rsp_data
);

   ncas_pkg::token_type        tok [NUM_CENTERS+1];
   logic [NUM_CENTERS-1:0]     active;
   logic                       accept;
   logic                       load_acc;
   ncas_pkg::point_type        req_point;

   assign accept   = start & ~busy;
   assign load_acc = accept & (req_data.op == ncas_pkg::OP_LOAD);

   assign req_point.x = req_data.coord_x;
   assign req_point.y = req_data.coord_y;
   assign req_point.z = req_data.coord_z;
   assign req_point.w = req_data.coord_w;

   always_comb begin
      tok[0].valid    = accept & (req_data.op == ncas_pkg::OP_POINT);
      tok[0].set_end  = req_data.set_end;
      tok[0].point    = req_point;
      tok[0].best_d   = ncas_pkg::DIST_MAX;
      tok[0].best_idx = '0;
   end

   for (genvar i = 0; i < NUM_CENTERS; i++) begin : g_cell
      localparam logic [ncas_pkg::IDX_W-1:0] IDX = ncas_pkg::IDX_W'(i);
      ncas_cell #(
         .CELL_IDX (IDX)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .load_en   (load_acc & (req_data.center_slot == IDX)),
         .load_data (req_point),
         .tok_in    (tok[i]),
         .tok_out   (tok[i+1]),
         .active    (active[i])
      );
   end

   assign busy = |active;

   ncas_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .tok_in    (tok[NUM_CENTERS]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0(active))
      else $error("more than one point in the cell chain");

   a_point_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.op == ncas_pkg::OP_POINT) |=> busy)
      else $error("accepted point did not raise busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a point in flight");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_sse_covers_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.sse_total >= ncas_pkg::SSE_W'(rsp_data.distance_sq)))
      else $error("SSE below the point's own distance");

endmodule
